[design/ewl_pkg.sv]
// Shared types and constants for the EEPROM area wear leveler.
// Depends on nothing; imported by the controller, the datapath and the top level.
package ewl_pkg;

   // Store geometry
   localparam int AREAS      = 8;
   localparam int SLOTS      = 32;
   localparam int AREA_W     = $clog2(AREAS);
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int MEM_ADDR_W = AREA_W + SLOT_W;
   localparam int MEM_DEPTH  = AREAS * SLOTS;

   // Field widths
   localparam int DATA_W     = 8;
   localparam int AREAS_W    = 4;
   localparam int CSR_IDX_W  = 1;

   localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_AREA_COUNT = 1'b0,
      CSR_AREAS_IN_USE   = 1'b1
   } csr_idx_type;

   // Request kinds
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DECIDE,
      ST_OPEN_NEW,
      ST_OPEN_PREV,
      ST_BUMP,
      ST_DATA_WR,
      ST_READ_RD,
      ST_RESP
   } ewl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_rd;
      logic scan_next;
      logic capture_live;
      logic decide;
      logic open_new;
      logic open_prev;
      logic bump;
      logic data_wr;
      logic read_rd;
   } ewl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;
      logic scan_last;
      logic found;
      logic is_read;
      logic move;
      logic save_all;
   } ewl_stat_type;

endpackage

[design/eeprom_area_wear_leveler.sv]
// Top level of the EEPROM area wear leveler.
// Depends on ewl_pkg, ewl_ctrl and ewl_dpath.
//
// Usage:
//   Request channel: present req_type, req_addr, req_wdata and req_save_all
//   with start high while busy is low; the beat is taken at that clock edge.
//   Result channel: exactly one result per request. rsp_valid is high for
//   one cycle with rsp_rdata, rsp_live_area, rsp_rewrite_request and
//   rsp_recovered; the receiver cannot stall, so it must take it then.
//   Config: csr_we with csr_index and csr_wdata writes a register at the
//   edge; write only while busy is low.
// Sequence:
//   The sequencer reads the area counters one at a time through the single
//   store port; 1 to 8 counters are examined. One or two store writes, a
//   data read, or both follow the scan before the strobe, and busy drops
//   the cycle after the strobe. One request is in flight at a time.
// Reset:
//   Synchronous, active high. Registers return to 255 and 8, the store
//   reads as erased (0xFF) everywhere, so the first request recovers.
module eeprom_area_wear_leveler
   import ewl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [SLOT_W-1:0]      req_addr,
   input  logic [DATA_W-1:0]      req_wdata,
   input  logic                   req_save_all,
   output logic                   rsp_valid,
   output logic [DATA_W-1:0]      rsp_rdata,
   output logic [AREA_W-1:0]      rsp_live_area,
   output logic                   rsp_rewrite_request,
   output logic                   rsp_recovered,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   ewl_cmd_type  cmd;
   ewl_stat_type stat;

   // Sequencer
   ewl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Store and decision logic
   ewl_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_addr            (req_addr),
      .req_wdata           (req_wdata),
      .req_save_all        (req_save_all),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_rdata           (rsp_rdata),
      .rsp_live_area       (rsp_live_area),
      .rsp_rewrite_request (rsp_rewrite_request),
      .rsp_recovered       (rsp_recovered)
   );

endmodule

[design/ewl_ctrl.sv]
// Sequencer of the EEPROM area wear leveler: counter scan, decision, store writes, data reads.
// Depends on ewl_pkg; drives the command struct of ewl_dpath.
module ewl_ctrl
   import ewl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ewl_stat_type stat,
   output ewl_cmd_type  cmd,
   output logic         busy,
   output logic         rsp_valid
);

   ewl_state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (stat.hit || stat.scan_last) state_in = ST_DECIDE;
            else                            state_in = ST_SCAN_RD;
         end
         ST_DECIDE: begin
            priority if (!stat.found) state_in = ST_OPEN_NEW;
            else if (stat.is_read)    state_in = ST_READ_RD;
            else if (stat.move)       state_in = ST_OPEN_NEW;
            else                      state_in = ST_BUMP;
         end
         ST_OPEN_NEW:  state_in = ST_OPEN_PREV;
         ST_OPEN_PREV: state_in = stat.is_read ? ST_READ_RD : ST_RESP;
         ST_BUMP:      state_in = stat.save_all ? ST_RESP : ST_DATA_WR;
         ST_DATA_WR:   state_in = ST_RESP;
         ST_READ_RD:   state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands per state
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:      cmd.load_req = start;
         ST_SCAN_RD:   cmd.scan_rd = 1'b1;
         ST_SCAN_CHK: begin
            cmd.capture_live = stat.hit;
            cmd.scan_next    = !stat.hit && !stat.scan_last;
         end
         ST_DECIDE:    cmd.decide = 1'b1;
         ST_OPEN_NEW:  cmd.open_new = 1'b1;
         ST_OPEN_PREV: cmd.open_prev = 1'b1;
         ST_BUMP:      cmd.bump = 1'b1;
         ST_DATA_WR:   cmd.data_wr = 1'b1;
         ST_READ_RD:   cmd.read_rd = 1'b1;
         ST_RESP:      cmd = '0;
         default:      cmd = '0;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   // One strobe per request, then back to idle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_resp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after delivering its result");

   a_start_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SCAN_RD))
      else $error("accepted request did not start the counter scan");

endmodule

[design/ewl_dpath.sv]
// Datapath of the EEPROM area wear leveler: request and config registers,
// byte store with per-entry valid bits, scan and decision logic. Depends on ewl_pkg.
module ewl_dpath
   import ewl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ewl_cmd_type            cmd,
   output ewl_stat_type           stat,
   input  logic                   req_type,
   input  logic [SLOT_W-1:0]      req_addr,
   input  logic [DATA_W-1:0]      req_wdata,
   input  logic                   req_save_all,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata,
   output logic [DATA_W-1:0]      rsp_rdata,
   output logic [AREA_W-1:0]      rsp_live_area,
   output logic                   rsp_rewrite_request,
   output logic                   rsp_recovered
);

   // Configuration
   logic [DATA_W-1:0]  max_ff;
   logic [AREAS_W-1:0] areas_ff;

   // Request beat
   logic               type_ff;
   logic [SLOT_W-1:0]  addr_ff;
   logic [DATA_W-1:0]  wdata_ff;
   logic               save_ff;

   // Scan and decision
   logic [AREA_W-1:0]  scan_ff;
   logic               found_ff;
   logic [DATA_W-1:0]  count_ff;
   logic [AREA_W-1:0]  area_ff;
   logic               rewrite_ff;
   logic               recovered_ff;

   // Store
   logic [DATA_W-1:0]  store_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [DATA_W-1:0]  q_ff;

   logic [AREA_W-1:0]     last_area;
   logic [AREA_W-1:0]     prev_area;
   logic [AREA_W-1:0]     next_area;
   logic                  move;
   logic                  mem_we;
   logic                  mem_re;
   logic [MEM_ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0]     mem_wd;

   // Effective last area: zero counts as one, saturate at the store size
   always_comb begin
      priority if (areas_ff == '0)
         last_area = '0;
      else if ({1'b0, areas_ff} > (AREAS_W+1)'(AREAS))
         last_area = AREA_W'(AREAS - 1);
      else
         last_area = AREA_W'(areas_ff - AREAS_W'(1));
   end

   assign prev_area = (area_ff != '0) ? area_ff - AREA_W'(1) : last_area;
   assign next_area = (area_ff == last_area) ? '0 : area_ff + AREA_W'(1);

   // Move when count > max - 2, done unsigned as count + 2 > max
   assign move = ({1'b0, count_ff} + (DATA_W+1)'(2)) > {1'b0, max_ff};

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= DATA_W'(255);
         areas_ff <= AREAS_W'(AREAS);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAX_AREA_COUNT: max_ff   <= csr_wdata;
            CSR_AREAS_IN_USE:   areas_ff <= csr_wdata[AREAS_W-1:0];
         endcase
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff  <= req_type;
         addr_ff  <= req_addr;
         wdata_ff <= req_wdata;
         save_ff  <= req_save_all;
      end
   end

   // Scan pointer, live area and result flags
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         area_ff      <= '0;
         rewrite_ff   <= 1'b0;
         recovered_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            scan_ff      <= '0;
            found_ff     <= 1'b0;
            rewrite_ff   <= 1'b0;
            recovered_ff <= 1'b0;
         end
         if (cmd.scan_next) scan_ff <= scan_ff + AREA_W'(1);
         if (cmd.capture_live) begin
            found_ff <= 1'b1;
            area_ff  <= scan_ff;
         end
         if (cmd.decide) begin
            priority if (!found_ff) begin
               area_ff      <= '0;
               rewrite_ff   <= 1'b1;
               recovered_ff <= 1'b1;
            end else if (type_ff == REQ_READ) begin
               rewrite_ff <= 1'b0;
            end else if (move) begin
               area_ff    <= next_area;
               rewrite_ff <= 1'b1;
            end else begin
               rewrite_ff <= save_ff;
            end
         end
      end
   end

   // Counter of the live area
   always_ff @(posedge clock) begin
      if (cmd.capture_live) count_ff <= q_ff;
   end

   // Store port: one access per cycle
   always_comb begin
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = {scan_ff, SLOT_W'(0)};
      mem_wd   = wdata_ff;
      priority if (cmd.scan_rd) begin
         mem_re = 1'b1;
      end else if (cmd.read_rd) begin
         mem_re   = 1'b1;
         mem_addr = {area_ff, addr_ff};
      end else if (cmd.open_new) begin
         mem_we   = 1'b1;
         mem_addr = {area_ff, SLOT_W'(0)};
         mem_wd   = DATA_W'(1);
      end else if (cmd.open_prev) begin
         mem_we   = 1'b1;
         mem_addr = {prev_area, SLOT_W'(0)};
         mem_wd   = max_ff;
      end else if (cmd.bump) begin
         mem_we   = 1'b1;
         mem_addr = {area_ff, SLOT_W'(0)};
         mem_wd   = count_ff + DATA_W'(1);
      end else if (cmd.data_wr) begin
         mem_we   = 1'b1;
         mem_addr = {area_ff, addr_ff};
      end
   end

   // Store array, no reset
   always_ff @(posedge clock) begin
      if (mem_we) store_ff[mem_addr] <= mem_wd;
   end

   // Valid bits: an unwritten entry reads as erased
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_addr] <= 1'b1;
      end
   end

   // Registered read data
   always_ff @(posedge clock) begin
      if (mem_re) q_ff <= vld_ff[mem_addr] ? store_ff[mem_addr] : ERASED_BYTE;
   end

   assign stat.hit       = (q_ff < max_ff);
   assign stat.scan_last = (scan_ff == last_area);
   assign stat.found     = found_ff;
   assign stat.is_read   = (type_ff == REQ_READ);
   assign stat.move      = move;
   assign stat.save_all  = save_ff;

   assign rsp_rdata           = (type_ff == REQ_READ) ? q_ff : '0;
   assign rsp_live_area       = area_ff;
   assign rsp_rewrite_request = rewrite_ff;
   assign rsp_recovered       = recovered_ff;

   // Recovery always asks for a rewrite
   a_recover_rewrites: assert property (@(posedge clock) disable iff (reset)
      recovered_ff |-> rewrite_ff)
      else $error("recovery without rewrite request");

   // The live area stays inside the rotated range once decided
   a_area_in_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.decide) |-> (area_ff <= last_area))
      else $error("live area beyond the last area in use");

   // Scan never runs past the last area
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_next |-> (scan_ff != last_area))
      else $error("counter scan stepped past the last area");

endmodule
